[hdl/v2d_pkg.sv]
package v2d_pkg;

    localparam int unsigned WORD_WIDTH_DEF = 32;
    localparam int unsigned FRAC_BITS_DEF  = 16;
    localparam int unsigned KIND_WIDTH     = 3;

    typedef logic [KIND_WIDTH-1:0] kind_t;

    localparam kind_t KIND_ADD    = 3'd0;
    localparam kind_t KIND_SUB    = 3'd1;
    localparam kind_t KIND_SCALE  = 3'd2;
    localparam kind_t KIND_LENGTH = 3'd3;
    localparam kind_t KIND_NORM   = 3'd4;

endpackage

[hdl/vector2d_alu_top.sv]
// Two-dimensional vector unit in signed fixed point (WORD_WIDTH bits, FRAC_BITS
// fraction bits). Each transaction selects add, subtract, scale, length or
// normalise; add, subtract and scale saturate and raise overflow, normalising
// the zero vector gives zeros and raises zero_length, unused kinds give all
// zeros. The unit is a single pipeline that accepts one transaction every
// cycle while not stalled and returns results in order (default Q16.16). Its
// depth is set by the square root, which resolves one root bit per stage,
// followed by the divider for normalise, which resolves one quotient bit per
// stage. Every kind travels the same path, so ordering is kept. in_stall
// rises only when the output register holds a result that is being stalled;
// the whole pipeline then holds in place.
module vector2d_alu_top #(
    parameter int unsigned WORD_WIDTH = v2d_pkg::WORD_WIDTH_DEF,
    parameter int unsigned FRAC_BITS  = v2d_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  v2d_pkg::kind_t         kind,
    input  logic [WORD_WIDTH-1:0]  first_x,
    input  logic [WORD_WIDTH-1:0]  first_y,
    input  logic [WORD_WIDTH-1:0]  second_x,
    input  logic [WORD_WIDTH-1:0]  second_y,
    input  logic [WORD_WIDTH-1:0]  factor,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [WORD_WIDTH-1:0]  result_x,
    output logic [WORD_WIDTH-1:0]  result_y,
    output logic [WORD_WIDTH-1:0]  magnitude,
    output logic                   overflow,
    output logic                   zero_length
);
    import v2d_pkg::*;

    localparam int unsigned W      = WORD_WIDTH;
    localparam int unsigned F      = FRAC_BITS;
    localparam int unsigned PW     = 2 * W;       // products and squares
    localparam int unsigned NW     = W + F;       // divider numerator
    localparam int unsigned QW     = F + 1;       // quotient never exceeds 2^F
    localparam int unsigned NSTAGE = W + F + 6;

    // Stage A: registered transaction
    typedef struct packed {
        kind_t          kind;
        logic [W-1:0]   ax;
        logic [W-1:0]   ay;
        logic [W-1:0]   bx;
        logic [W-1:0]   by;
        logic [W-1:0]   f;
    } a_t;

    // Stage B: magnitudes, products and add/subtract result
    typedef struct packed {
        kind_t          kind;
        logic [W-1:0]   asx;
        logic [W-1:0]   asy;
        logic           asov;
        logic           snx;
        logic           sny;
        logic [PW-1:0]  px;
        logic [PW-1:0]  py;
        logic [PW-1:0]  sqx;
        logic [PW-1:0]  sqy;
        logic [W-1:0]   mx;
        logic [W-1:0]   my;
        logic           nx;
        logic           ny;
    } b_t;

    // Square root stages
    typedef struct packed {
        kind_t          kind;
        logic [W-1:0]   rx;
        logic [W-1:0]   ry;
        logic           ov;
        logic           nx;
        logic           ny;
        logic [W-1:0]   mx;
        logic [W-1:0]   my;
        logic [PW-1:0]  s;
        logic [W-1:0]   r;
        logic [PW-1:0]  sq;
    } sq_t;

    // Divider stages
    typedef struct packed {
        kind_t          kind;
        logic [W-1:0]   rx;
        logic [W-1:0]   ry;
        logic           ov;
        logic           nx;
        logic           ny;
        logic [W-1:0]   len;
        logic [NW-1:0]  remx;
        logic [NW-1:0]  remy;
        logic [QW-1:0]  qx;
        logic [QW-1:0]  qy;
    } dv_t;

    function automatic logic [W:0] scale_pack(input logic [PW-1:0] p, input logic neg);
        logic [PW-1:0] t;
        logic [PW-1:0] lim;
        logic [W-1:0]  v;
        logic          ov;
        t   = (p + (PW'(1) << (F - 1))) >> F;
        lim = neg ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
        ov  = 1'b0;
        v   = t[W-1:0];
        if (t > lim)
        begin
            v  = lim[W-1:0];
            ov = 1'b1;
        end
        return {ov, neg ? (W'(0) - v) : v};
    endfunction

    logic              en;
    logic [NSTAGE-1:0] vld_reg;
    a_t                a_reg;
    b_t                b_reg, b_next;
    sq_t               sq_reg [0:W];
    sq_t               sq_next [0:W];
    dv_t               dv_reg [0:QW];
    dv_t               dv_next [0:QW];
    logic [W-1:0]      rx_next, ry_next, mag_next;
    logic              ov_next, zl_next;
    logic [W-1:0]      rx_reg, ry_reg, mag_reg;
    logic              ov_reg, zl_reg;

    // Advance everything unless the output holds a stalled result
    assign en       = !(vld_reg[NSTAGE-1] && out_stall);
    assign in_stall = !en;

    // Stage B: add/subtract with saturation, sign split, multiplications
    always_comb
    begin
        logic [W:0]   ex, ey, fx, fy, sx, sy;
        logic [W-1:0] mf;
        ex = {a_reg.ax[W-1], a_reg.ax};
        ey = {a_reg.ay[W-1], a_reg.ay};
        fx = {a_reg.bx[W-1], a_reg.bx};
        fy = {a_reg.by[W-1], a_reg.by};
        sx = (a_reg.kind == KIND_SUB) ? (ex - fx) : (ex + fx);
        sy = (a_reg.kind == KIND_SUB) ? (ey - fy) : (ey + fy);
        b_next.kind = a_reg.kind;
        b_next.asx  = (sx[W] != sx[W-1]) ? {sx[W], {(W-1){~sx[W]}}} : sx[W-1:0];
        b_next.asy  = (sy[W] != sy[W-1]) ? {sy[W], {(W-1){~sy[W]}}} : sy[W-1:0];
        b_next.asov = (sx[W] != sx[W-1]) || (sy[W] != sy[W-1]);
        b_next.nx   = a_reg.ax[W-1];
        b_next.ny   = a_reg.ay[W-1];
        b_next.mx   = a_reg.ax[W-1] ? (W'(0) - a_reg.ax) : a_reg.ax;
        b_next.my   = a_reg.ay[W-1] ? (W'(0) - a_reg.ay) : a_reg.ay;
        mf          = a_reg.f[W-1] ? (W'(0) - a_reg.f) : a_reg.f;
        b_next.snx  = a_reg.ax[W-1] ^ a_reg.f[W-1];
        b_next.sny  = a_reg.ay[W-1] ^ a_reg.f[W-1];
        b_next.px   = PW'(b_next.mx) * PW'(mf);
        b_next.py   = PW'(b_next.my) * PW'(mf);
        b_next.sqx  = PW'(b_next.mx) * PW'(b_next.mx);
        b_next.sqy  = PW'(b_next.my) * PW'(b_next.my);
    end

    // Stage C: scale rounding, early results, sum of squares
    always_comb
    begin
        logic [W:0] scx, scy;
        scx = scale_pack(b_reg.px, b_reg.snx);
        scy = scale_pack(b_reg.py, b_reg.sny);
        sq_next[0].kind = b_reg.kind;
        sq_next[0].nx   = b_reg.nx;
        sq_next[0].ny   = b_reg.ny;
        sq_next[0].mx   = b_reg.mx;
        sq_next[0].my   = b_reg.my;
        sq_next[0].s    = b_reg.sqx + b_reg.sqy;
        sq_next[0].r    = '0;
        sq_next[0].sq   = '0;
        sq_next[0].rx   = '0;
        sq_next[0].ry   = '0;
        sq_next[0].ov   = 1'b0;
        case (b_reg.kind)
            KIND_ADD, KIND_SUB:
            begin
                sq_next[0].rx = b_reg.asx;
                sq_next[0].ry = b_reg.asy;
                sq_next[0].ov = b_reg.asov;
            end
            KIND_SCALE:
            begin
                sq_next[0].rx = scx[W-1:0];
                sq_next[0].ry = scy[W-1:0];
                sq_next[0].ov = scx[W] | scy[W];
            end
            default:
            begin
                sq_next[0].rx = '0;
            end
        endcase
    end

    // Square root: one root bit per stage, squares kept incrementally
    for (genvar k = 0; k < W; k++)
    begin : g_root
        always_comb
        begin
            logic [PW-1:0] c2;
            c2 = sq_reg[k].sq + (PW'(sq_reg[k].r) << (W - k))
                 + (PW'(1) << (2 * (W - 1 - k)));
            sq_next[k+1] = sq_reg[k];
            if (c2 <= sq_reg[k].s)
            begin
                sq_next[k+1].sq = c2;
                sq_next[k+1].r  = sq_reg[k].r | (W'(1) << (W - 1 - k));
            end
        end
    end

    // Divider entry
    always_comb
    begin
        dv_next[0].kind = sq_reg[W].kind;
        dv_next[0].rx   = sq_reg[W].rx;
        dv_next[0].ry   = sq_reg[W].ry;
        dv_next[0].ov   = sq_reg[W].ov;
        dv_next[0].nx   = sq_reg[W].nx;
        dv_next[0].ny   = sq_reg[W].ny;
        dv_next[0].len  = sq_reg[W].r;
        dv_next[0].remx = NW'(sq_reg[W].mx) << F;
        dv_next[0].remy = NW'(sq_reg[W].my) << F;
        dv_next[0].qx   = '0;
        dv_next[0].qy   = '0;
    end

    // Restoring division: one quotient bit per stage
    for (genvar j = 0; j < QW; j++)
    begin : g_div
        always_comb
        begin
            logic [NW-1:0] d;
            d = NW'(dv_reg[j].len) << (F - j);
            dv_next[j+1] = dv_reg[j];
            if (dv_reg[j].remx >= d)
            begin
                dv_next[j+1].remx = dv_reg[j].remx - d;
                dv_next[j+1].qx   = dv_reg[j].qx | (QW'(1) << (F - j));
            end
            if (dv_reg[j].remy >= d)
            begin
                dv_next[j+1].remy = dv_reg[j].remy - d;
                dv_next[j+1].qy   = dv_reg[j].qy | (QW'(1) << (F - j));
            end
        end
    end

    // Output formatting
    always_comb
    begin
        rx_next  = dv_reg[QW].rx;
        ry_next  = dv_reg[QW].ry;
        ov_next  = dv_reg[QW].ov;
        mag_next = '0;
        zl_next  = 1'b0;
        case (dv_reg[QW].kind)
            KIND_LENGTH:
            begin
                mag_next = dv_reg[QW].len;
            end
            KIND_NORM:
            begin
                mag_next = dv_reg[QW].len;
                if (dv_reg[QW].len == '0)
                begin
                    zl_next = 1'b1;
                    rx_next = '0;
                    ry_next = '0;
                end
                else
                begin
                    rx_next = dv_reg[QW].nx ? (W'(0) - W'(dv_reg[QW].qx)) : W'(dv_reg[QW].qx);
                    ry_next = dv_reg[QW].ny ? (W'(0) - W'(dv_reg[QW].qy)) : W'(dv_reg[QW].qy);
                end
            end
            default:
            begin
                mag_next = '0;
            end
        endcase
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], in_valid};
        end
    end

    // Payload: hold while stalled, advance otherwise
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= '{kind: kind, ax: first_x, ay: first_y, bx: second_x,
                           by: second_y, f: factor};
            b_reg     <= b_next;
            for (int k = 0; k <= W; k++)
            begin
                sq_reg[k] <= sq_next[k];
            end
            for (int j = 0; j <= QW; j++)
            begin
                dv_reg[j] <= dv_next[j];
            end
            rx_reg    <= rx_next;
            ry_reg    <= ry_next;
            mag_reg   <= mag_next;
            ov_reg    <= ov_next;
            zl_reg    <= zl_next;
        end
    end

    assign out_valid   = vld_reg[NSTAGE-1];
    assign result_x    = rx_reg;
    assign result_y    = ry_reg;
    assign magnitude   = mag_reg;
    assign overflow    = ov_reg;
    assign zero_length = zl_reg;

`ifndef ASSERT_OFF
    a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_length |-> magnitude == '0 && result_x == '0 && result_y == '0)
        else $error("zero_length with non-zero result");

    a_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> magnitude == '0 && !zero_length)
        else $error("overflow together with length result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule

[dv/tb_vector2d_alu_top.sv]
module tb_vector2d_alu_top;
    timeunit 1ns;
    timeprecision 1ps;

    import v2d_pkg::*;

    localparam int W = int'(WORD_WIDTH_DEF);
    localparam int F = int'(FRAC_BITS_DEF);
    localparam int LATENCY = W + F + 6;
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1350;

    typedef logic [W-1:0] word_t;

    typedef struct packed {
        word_t rx;
        word_t ry;
        word_t mag;
        logic  ov;
        logic  zl;
    } vec_result_t;

    // ------------------------------------------------------------------
    // Predictor: exact integer arithmetic at the block's widths
    // ------------------------------------------------------------------
    function automatic word_t saturate(input logic signed [127:0] v, inout logic ov);
        logic signed [127:0] hi_lim;
        logic signed [127:0] lo_lim;
        hi_lim = (128'sd1 <<< (W - 1)) - 1;
        lo_lim = -(128'sd1 <<< (W - 1));
        if (v > hi_lim)
        begin
            ov = 1'b1;
            return hi_lim[W-1:0];
        end
        if (v < lo_lim)
        begin
            ov = 1'b1;
            return lo_lim[W-1:0];
        end
        return v[W-1:0];
    endfunction

    function automatic word_t scaled_component(input word_t a, input word_t f, inout logic ov);
        logic [127:0] ma;
        logic [127:0] mf;
        logic [127:0] p;
        logic         neg;
        ma = a[W-1] ? (128'(1) << W) - 128'(a) : 128'(a);
        mf = f[W-1] ? (128'(1) << W) - 128'(f) : 128'(f);
        neg = a[W-1] ^ f[W-1];
        p = (ma * mf + (128'(1) << (F - 1))) >> F;
        return saturate(neg ? -$signed(p) : $signed(p), ov);
    endfunction

    function automatic logic [63:0] isqrt(input logic [127:0] s);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 50; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= s)
                r = c;
        end
        return r;
    endfunction

    function automatic word_t unit_component(input word_t a, input logic [63:0] len);
        logic [127:0] m;
        logic [127:0] q;
        logic         dummy;
        m = a[W-1] ? (128'(1) << W) - 128'(a) : 128'(a);
        q = (m << F) / 128'(len);
        dummy = 1'b0;
        return saturate(a[W-1] ? -$signed(q) : $signed(q), dummy);
    endfunction

    function automatic vec_result_t predict_vector(input kind_t k, input word_t ax,
                                                   input word_t ay, input word_t bx,
                                                   input word_t by, input word_t f);
        vec_result_t         r;
        logic signed [127:0] sx;
        logic signed [127:0] sy;
        logic [127:0]        mx;
        logic [127:0]        my;
        logic [63:0]         len;
        r = '0;
        case (k)
            KIND_ADD, KIND_SUB:
            begin
                sx = (k == KIND_ADD) ? 128'($signed(ax)) + 128'($signed(bx))
                                     : 128'($signed(ax)) - 128'($signed(bx));
                sy = (k == KIND_ADD) ? 128'($signed(ay)) + 128'($signed(by))
                                     : 128'($signed(ay)) - 128'($signed(by));
                r.rx = saturate(sx, r.ov);
                r.ry = saturate(sy, r.ov);
            end
            KIND_SCALE:
            begin
                r.rx = scaled_component(ax, f, r.ov);
                r.ry = scaled_component(ay, f, r.ov);
            end
            KIND_LENGTH, KIND_NORM:
            begin
                mx = ax[W-1] ? (128'(1) << W) - 128'(ax) : 128'(ax);
                my = ay[W-1] ? (128'(1) << W) - 128'(ay) : 128'(ay);
                len = isqrt(mx * mx + my * my);
                r.mag = len[W-1:0];
                if (k == KIND_NORM)
                begin
                    if (r.mag == '0)
                        r.zl = 1'b1;
                    else
                    begin
                        r.rx = unit_component(ax, 64'(r.mag));
                        r.ry = unit_component(ay, 64'(r.mag));
                    end
                end
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: holds the expected results in arrival order
    // ------------------------------------------------------------------
    class vector_scoreboard;
        vec_result_t pending[$];
        int          mismatches;
        int          checked;

        function void note_input(input kind_t k, input word_t ax, input word_t ay,
                                 input word_t bx, input word_t by, input word_t f);
            pending.push_back(predict_vector(k, ax, ay, bx, by, f));
        endfunction

        function void check_result(input vec_result_t got);
            vec_result_t want;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.rx !== want.rx || got.ry !== want.ry || got.mag !== want.mag ||
                got.ov !== want.ov || got.zl !== want.zl)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: result %0d exp x=%h y=%h mag=%h ov=%b zl=%b",
                             checked, want.rx, want.ry, want.mag, want.ov, want.zl);
                    $display("       got x=%h y=%h mag=%h ov=%b zl=%b",
                             got.rx, got.ry, got.mag, got.ov, got.zl);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block and its signals
    // ------------------------------------------------------------------
    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    kind_t kind;
    word_t first_x, first_y, second_x, second_y, factor;
    logic  out_valid;
    logic  out_stall;
    word_t result_x, result_y, magnitude;
    logic  overflow, zero_length;

    vector2d_alu_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .first_x    (first_x),
        .first_y    (first_y),
        .second_x   (second_x),
        .second_y   (second_y),
        .factor     (factor),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_x   (result_x),
        .result_y   (result_y),
        .magnitude  (magnitude),
        .overflow   (overflow),
        .zero_length(zero_length)
    );

    vector_scoreboard board = new();

    int  sent_count;
    int  idle_cycles;
    int  stall_run;
    int  kind_seen[8];

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        out_stall = 1'b0;
        kind      = KIND_ADD;
        first_x   = '0;
        first_y   = '0;
        second_x  = '0;
        second_y  = '0;
        factor    = '0;
    end

    // Gap length: mostly short, now and then long, sometimes none at all
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 70);
    endfunction

    // Drive one transaction and hold it until the block takes it
    task automatic send_vector(input kind_t k, input word_t ax, input word_t ay,
                               input word_t bx, input word_t by, input word_t f);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        first_x  <= ax;
        first_y  <= ay;
        second_x <= bx;
        second_y <= by;
        factor   <= f;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // accepted at this edge: note it before anything else moves
        board.note_input(k, ax, ay, bx, by, f);
        kind_seen[k]++;
        sent_count++;
    endtask

    // Random word biased towards edges, small values and full-range noise
    function automatic word_t pick_word();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(W-1){1'b1}}};
            1: return {1'b1, {(W-1){1'b0}}};
            2: return word_t'($signed(32'($urandom_range(0, 2000)) - 1000));
            3: return word_t'($urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000);
            4: return '0;
            5: return word_t'($signed($urandom()) >>> $urandom_range(0, 24));
            default: return word_t'($urandom());
        endcase
    endfunction

    // Receiver: random stalls, mostly short with a long run now and then,
    // checks each accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_result('{result_x, result_y, magnitude, overflow, zero_length});
            if (stall_run > 0)
            begin
                out_stall <= 1'b1;
                stall_run <= stall_run - 1;
            end
            else if ($urandom_range(0, 99) < 2)
            begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(8, 60);
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < 8) ? 1'b1 :
                             ($urandom_range(0, 99) < 25) ? ($urandom_range(0, 3) == 0) : 1'b0;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: drop the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        word_t maxp;
        word_t minn;
        int    drain;
        maxp = {1'b0, {(W-1){1'b1}}};
        minn = {1'b1, {(W-1){1'b0}}};
        sent_count   = 0;
        idle_cycles  = 0;
        stall_run    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every kind, field extremes, saturation, zero vector
        send_vector(KIND_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, '0);
        send_vector(KIND_ADD, maxp, minn, 32'd1, 32'hFFFF_FFFF, '0);
        send_vector(KIND_ADD, minn, maxp, minn, maxp, '0);
        send_vector(KIND_SUB, 32'h0005_0000, 32'h0001_0000, 32'h0002_0000, 32'h0007_0000, '0);
        send_vector(KIND_SUB, minn, maxp, 32'd1, 32'hFFFF_FFFF, '0);
        send_vector(KIND_SUB, '0, '0, minn, maxp, '0);
        send_vector(KIND_SCALE, 32'h0002_0000, 32'hFFFD_0000, '0, '0, 32'h0001_8000);
        send_vector(KIND_SCALE, maxp, minn, '0, '0, maxp);
        send_vector(KIND_SCALE, minn, minn, '0, '0, minn);
        send_vector(KIND_SCALE, 32'd1, 32'hFFFF_FFFF, '0, '0, 32'h0000_8000);
        send_vector(KIND_SCALE, 32'd3, 32'hFFFF_FFFD, '0, '0, 32'h0000_8000);
        send_vector(KIND_LENGTH, 32'h0003_0000, 32'h0004_0000, '0, '0, '0);
        send_vector(KIND_LENGTH, minn, minn, '0, '0, '0);
        send_vector(KIND_LENGTH, maxp, minn, '0, '0, '0);
        send_vector(KIND_NORM, 32'h0003_0000, 32'hFFFC_0000, '0, '0, '0);
        send_vector(KIND_NORM, '0, '0, '0, '0, '0);
        send_vector(KIND_NORM, 32'd1, '0, '0, '0, '0);
        send_vector(KIND_NORM, minn, 32'd1, '0, '0, '0);
        send_vector(KIND_NORM, maxp, maxp, '0, '0, '0);
        send_vector(kind_t'(5), maxp, minn, maxp, minn, maxp);
        send_vector(kind_t'(6), '1, '1, '1, '1, '1);
        send_vector(kind_t'(7), 32'h1234_5678, '0, '0, '0, '0);

        // Random: mostly the five operations, a little of the unused kinds
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind_t k;
            k = ($urandom_range(0, 49) == 0) ? kind_t'($urandom_range(5, 7))
                                             : kind_t'($urandom_range(0, 4));
            send_vector(k, pick_word(), pick_word(), pick_word(), pick_word(), pick_word());
        end
        in_valid     <= 1'b0;

        // Drain: wait for every expected result, then let the pipeline run empty before reporting
        drain = 0;
        while (board.pending.size() != 0 && drain < 50 * LATENCY + IDLE_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (LATENCY + 10) @(posedge clk);

        $display("Run covered %0d transactions: add %0d, sub %0d, scale %0d, length %0d,",
                 sent_count, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        $display("normalise %0d, unused %0d; results checked %0d, mismatches %0d.",
                 kind_seen[4], kind_seen[5] + kind_seen[6] + kind_seen[7],
                 board.checked, board.mismatches);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
